[rtl/crvc_pkg.sv]
`default_nettype none

package crvc_pkg;

    // field widths of one voxel
    localparam int COORD_BITS = 10;
    localparam int VALUE_BITS = 16;
    localparam int OUT_BITS   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // datapath widths
    // offset from start point, signed Q.6
    localparam int D_W    = ((COORD_BITS + 6 > 16) ? (COORD_BITS + 6) : 16) + 1;
    // offset times axis lane, signed Q.20
    localparam int P_W    = D_W + 16;
    // axial distance s20, signed Q.20
    localparam int S_W    = P_W + 2;
    // squared offset lane
    localparam int Q_W    = 2 * D_W;
    // squared offset length, Q.12
    localparam int L_W    = Q_W + 2;
    // axial limit axis_length * 2^14
    localparam int LIM_W  = 17 + 14;
    // s12 while the axial test holds
    localparam int S12_W  = LIM_W - 8;
    localparam int S12Q_W = 2 * S12_W;
    // slope times s12
    localparam int SP_W   = 24 + S12_W + 1;
    // squared distance from the axis, signed Q.24
    localparam int DST_W  = (((L_W + 12) > S12Q_W) ? (L_W + 12) : S12Q_W) + 1;
    // radius at s, signed Q.26
    localparam int R26_W  = (((16 + 20 + 1) > SP_W) ? (16 + 20 + 1) : SP_W) + 1;
    localparam int RQ_W   = R26_W - 14;
    // capped radius Q.12 and its square
    localparam int R12_W  = 30;
    localparam int R12Q_W = 2 * R12_W;
    localparam int CMP_W  = ((DST_W - 1) > R12Q_W) ? (DST_W - 1) : R12Q_W;

    localparam logic [R12_W-1:0] R12_CAP = R12_W'(1) << 29;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X      = 3'd0,
        CFG_START_Y      = 3'd1,
        CFG_START_Z      = 3'd2,
        CFG_AXIS_UNIT    = 3'd3,
        CFG_AXIS_LENGTH  = 3'd4,
        CFG_RADIUS_START = 3'd5,
        CFG_RADIUS_SLOPE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        start_x;
        logic [15:0]        start_y;
        logic [15:0]        start_z;
        logic [47:0]        axis_unit;
        logic [16:0]        axis_length;
        logic [15:0]        radius_start;
        logic signed [23:0] radius_slope;
    } t_cone_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0] voxel_x;
        logic [COORD_BITS-1:0] voxel_y;
        logic [COORD_BITS-1:0] voxel_z;
        logic [VALUE_BITS-1:0] voxel_value;
    } t_vox_in;

    typedef struct packed {
        logic [OUT_BITS-1:0] value_out;
        logic                cleared;
    } t_vox_out;

endpackage

`default_nettype wire

[rtl/crvc_pipe.sv]
`default_nettype none

module crvc_pipe (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire crvc_pkg::t_cone_cfg i_cfg,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire crvc_pkg::t_vox_in   i_vox,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output crvc_pkg::t_vox_out       o_res
);

    localparam int NST = 9;

    localparam int D_W    = crvc_pkg::D_W;
    localparam int P_W    = crvc_pkg::P_W;
    localparam int S_W    = crvc_pkg::S_W;
    localparam int Q_W    = crvc_pkg::Q_W;
    localparam int L_W    = crvc_pkg::L_W;
    localparam int LIM_W  = crvc_pkg::LIM_W;
    localparam int S12_W  = crvc_pkg::S12_W;
    localparam int S12Q_W = crvc_pkg::S12Q_W;
    localparam int SP_W   = crvc_pkg::SP_W;
    localparam int DST_W  = crvc_pkg::DST_W;
    localparam int R26_W  = crvc_pkg::R26_W;
    localparam int RQ_W   = crvc_pkg::RQ_W;
    localparam int R12_W  = crvc_pkg::R12_W;
    localparam int R12Q_W = crvc_pkg::R12Q_W;
    localparam int CMP_W  = crvc_pkg::CMP_W;
    localparam int VB     = crvc_pkg::VALUE_BITS;

    // stage valids and per-stage load enables
    logic [NST:1] r_v;
    logic [NST:1] en;

    // value carried alongside the math
    logic [VB-1:0] r_val [1:NST-1];

    // axis lanes
    logic signed [15:0] axis [3];

    // stage 1: offsets from the start point
    logic signed [D_W-1:0] n_d [3];
    logic signed [D_W-1:0] r_d [3];
    // stage 2: products
    logic signed [P_W-1:0] n_pa [3];
    logic signed [P_W-1:0] r_pa [3];
    logic signed [Q_W-1:0] n_pq [3];
    logic signed [Q_W-1:0] r_pq [3];
    // stage 3: sums
    logic signed [S_W-1:0] n_s20;
    logic signed [S_W-1:0] r_s20;
    logic signed [L_W-1:0] n_len2;
    logic signed [L_W-1:0] r_len2_3;
    // stage 4: axial test
    logic                  n_pass;
    logic                  r_pass_4;
    logic [S12_W-1:0]      r_s12;
    logic signed [L_W-1:0] r_len2_4;
    // stage 5: s12 square and slope term
    logic [S12Q_W-1:0]      r_s12sq;
    logic signed [SP_W-1:0] n_sprod;
    logic signed [SP_W-1:0] r_sprod;
    logic signed [L_W-1:0]  r_len2_5;
    logic                   r_pass_5;
    // stage 6: distance and radius
    logic signed [DST_W-1:0] n_dist2;
    logic signed [DST_W-1:0] r_dist2_6;
    logic signed [R26_W-1:0] n_r26;
    logic signed [R26_W-1:0] r_r26;
    logic                    r_pass_6;
    // stage 7: radius in Q.12, capped
    logic [RQ_W-1:0]         rq;
    logic                    r26_pos;
    logic [R12_W-1:0]        n_r12;
    logic [R12_W-1:0]        r_r12;
    logic                    r_ok_7;
    logic signed [DST_W-1:0] r_dist2_7;
    // stage 8: radius square
    logic [R12Q_W-1:0]       r_r12sq;
    logic                    r_ok_8;
    logic signed [DST_W-1:0] r_dist2_8;
    // stage 9: output
    logic                    n_inside;
    crvc_pkg::t_vox_out      r_res;

    // stall chain: a stage loads when empty or when the next one moves
    always_comb begin
        en[NST] = !r_v[NST] || !i_stall;
        for (int k = NST - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_v[NST];
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // value delay line
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_val[1] <= i_vox.voxel_value;
        end
        for (int k = 2; k <= NST - 1; k++) begin
            if (en[k]) begin
                r_val[k] <= r_val[k-1];
            end
        end
    end

    assign axis[0] = $signed(i_cfg.axis_unit[15:0]);
    assign axis[1] = $signed(i_cfg.axis_unit[31:16]);
    assign axis[2] = $signed(i_cfg.axis_unit[47:32]);

    // stage 1: voxel * 64 - start
    always_comb begin
        n_d[0] = D_W'({i_vox.voxel_x, 6'b0}) - D_W'(i_cfg.start_x);
        n_d[1] = D_W'({i_vox.voxel_y, 6'b0}) - D_W'(i_cfg.start_y);
        n_d[2] = D_W'({i_vox.voxel_z, 6'b0}) - D_W'(i_cfg.start_z);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= n_d[i];
            end
        end
    end

    // stage 2: projection and length products, one multiplier each
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pa[i] = P_W'(r_d[i]) * P_W'(axis[i]);
            n_pq[i] = Q_W'(r_d[i]) * Q_W'(r_d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= n_pa[i];
                r_pq[i] <= n_pq[i];
            end
        end
    end

    // stage 3: sum of the three lanes
    assign n_s20  = S_W'(r_pa[0]) + S_W'(r_pa[1]) + S_W'(r_pa[2]);
    assign n_len2 = L_W'(r_pq[0]) + L_W'(r_pq[1]) + L_W'(r_pq[2]);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s20    <= n_s20;
            r_len2_3 <= n_len2;
        end
    end

    // stage 4: 0 <= s20 <= length * 2^14
    assign n_pass = !r_s20[S_W-1]
                    && ($unsigned(r_s20) <= S_W'({i_cfg.axis_length, 14'b0}));

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_pass_4 <= n_pass;
            r_s12    <= r_s20[LIM_W-1:8];
            r_len2_4 <= r_len2_3;
        end
    end

    // stage 5: s12 squared and slope * s12
    assign n_sprod = SP_W'(i_cfg.radius_slope) * SP_W'($signed({1'b0, r_s12}));

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s12sq  <= r_s12 * r_s12;
            r_sprod  <= n_sprod;
            r_len2_5 <= r_len2_4;
            r_pass_5 <= r_pass_4;
        end
    end

    // stage 6: squared distance from the axis and radius at s
    assign n_dist2 = DST_W'($signed({r_len2_5, 12'b0}))
                     - DST_W'($signed({1'b0, r_s12sq}));
    assign n_r26   = R26_W'($signed({1'b0, i_cfg.radius_start, 20'b0}))
                     - R26_W'(r_sprod);

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_dist2_6 <= n_dist2;
            r_r26     <= n_r26;
            r_pass_6  <= r_pass_5;
        end
    end

    // stage 7: floor to Q.12, cap, positive radius check
    assign rq      = r_r26[R26_W-1:14];
    assign r26_pos = !r_r26[R26_W-1] && (r_r26 != '0);
    assign n_r12   = (rq > RQ_W'(crvc_pkg::R12_CAP)) ? crvc_pkg::R12_CAP : rq[R12_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_r12     <= n_r12;
            r_ok_7    <= r_pass_6 && r26_pos && (rq != '0);
            r_dist2_7 <= r_dist2_6;
        end
    end

    // stage 8: squared radius
    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_r12sq   <= r_r12 * r_r12;
            r_ok_8    <= r_ok_7;
            r_dist2_8 <= r_dist2_7;
        end
    end

    // stage 9: a negative distance is below any positive square
    assign n_inside = r_ok_8
                      && (r_dist2_8[DST_W-1]
                          || (CMP_W'(r_dist2_8[DST_W-2:0]) < CMP_W'(r_r12sq)));

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_res.value_out <= n_inside ? '0 : crvc_pkg::OUT_BITS'(r_val[NST-1]);
            r_res.cleared   <= n_inside;
        end
    end

endmodule

`default_nettype wire

[rtl/cone_region_voxel_clear.sv]
// Clears voxels that fall inside a truncated cone. Each voxel transfer
// carries integer x, y, z and an intensity; the result transfer returns the
// intensity, or zero with cleared set when the voxel center lies within the
// cone given by the start point, unit axis, length, start radius and slope.
// The datapath is a nine-stage pipeline (offsets, products, lane sums, axial
// test, squares, distance and radius, radius rounding, radius square, final
// compare), and it takes a new voxel every cycle while the output is not
// stalled. When the output is stalled, empty stages still fill, and o_stall
// rises only once every stage holds a voxel. Configuration writes are always
// ready and pass through a register before the pipeline uses them; write
// them only while no voxel is in flight.
`default_nettype none

module cone_region_voxel_clear (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [crvc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [crvc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // voxel input
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire crvc_pkg::t_vox_in                 i_vox,
    // result output
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output crvc_pkg::t_vox_out                     o_res
);

    crvc_pkg::t_cone_cfg r_cfg;
    crvc_pkg::t_cone_cfg n_cfg;

    assign o_cfg_ready = 1'b1;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                crvc_pkg::CFG_START_X: begin
                    n_cfg.start_x = i_cfg_data[15:0];
                end
                crvc_pkg::CFG_START_Y: begin
                    n_cfg.start_y = i_cfg_data[15:0];
                end
                crvc_pkg::CFG_START_Z: begin
                    n_cfg.start_z = i_cfg_data[15:0];
                end
                crvc_pkg::CFG_AXIS_UNIT: begin
                    n_cfg.axis_unit = i_cfg_data[47:0];
                end
                crvc_pkg::CFG_AXIS_LENGTH: begin
                    n_cfg.axis_length = i_cfg_data[16:0];
                end
                crvc_pkg::CFG_RADIUS_START: begin
                    n_cfg.radius_start = i_cfg_data[15:0];
                end
                crvc_pkg::CFG_RADIUS_SLOPE: begin
                    n_cfg.radius_slope = $signed(i_cfg_data[23:0]);
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // cone test pipeline
    crvc_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_vox   (i_vox),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
